// ===== rtl/phi_wrapped_bin_lookup_core_defines.svh =====
// assertion macros shared by the bin lookup rtl
// no dependencies; included by the modules that carry assertions
`ifndef PHI_WRAPPED_BIN_LOOKUP_CORE_DEFINES_SVH
`define PHI_WRAPPED_BIN_LOOKUP_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PWBL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PWBL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pwbl_pkg.sv =====
// shared types and constants for the bin lookup core
// no dependencies; imported by every module of the block
`default_nettype none

package pwbl_pkg;

    localparam int SEL_W    = 6;
    localparam int CNT_W    = 7;
    localparam int SEL_SPAN = 64;

    localparam logic [CNT_W-1:0] BIN_COUNT_RST = 7'd64;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_LOOKUP,
        OP_REJECT
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_INDEX = 2'd1,
        STAT_NO_BIN    = 2'd2
    } status_t;

    // classified command as it travels from front to back
    typedef struct packed {
        op_t              op;
        logic [SEL_W-1:0] sel;
        logic [CNT_W-1:0] lim;
    } ctl_t;

endpackage

`default_nettype wire

// ===== rtl/pwbl_queue.sv =====
// two-entry command queue between the front and back sections
// depends on pwbl_pkg and the assertion macro header
`default_nettype none

`include "phi_wrapped_bin_lookup_core_defines.svh"

module pwbl_queue
    import pwbl_pkg::*;
#(
    parameter int DATA_W = 60
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ctl_t              push_ctl,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   empty,
    output ctl_t                   head_ctl,
    output logic [DATA_W-1:0]      head_data
);

    ctl_t              ctl_mem  [2];
    logic [DATA_W-1:0] data_mem [2];

    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign empty     = (count_reg == 2'd0);
    assign head_ctl  = ctl_mem[rd_ptr_reg];
    assign head_data = data_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctl_mem[wr_ptr_reg]  <= push_ctl;
            data_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    `PWBL_ASSERT_NOW(a_no_overflow, clk, rst_n, push, count_reg != 2'd2, "queue push while full")
    `PWBL_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, count_reg != 2'd0, "queue pop while empty")
    `PWBL_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_reg != 2'd3, "queue count corrupt")

endmodule

`default_nettype wire

// ===== rtl/pwbl_front.sv =====
// front section: bin count register, command capture and classification
// depends on pwbl_pkg; feeds pwbl_queue
`default_nettype none

module pwbl_front
    import pwbl_pkg::*;
#(
    parameter int MAX_BINS   = 64,
    parameter int ANGLE_BITS = 20
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         cfg_wr_en,
    input  wire logic [CNT_W-1:0]             cfg_wr_data,
    input  wire logic [1:0]                   mode,
    input  wire logic [SEL_W-1:0]             bin_sel,
    input  wire logic signed [ANGLE_BITS-1:0] angle,
    input  wire logic signed [ANGLE_BITS-1:0] bound_a,
    input  wire logic signed [ANGLE_BITS-1:0] bound_b,
    input  wire logic                         q_full,
    output logic                              q_push,
    output ctl_t                              q_push_ctl,
    output logic [3*ANGLE_BITS-1:0]           q_push_data
);

    localparam int W     = ANGLE_BITS;
    localparam int DEPTH = (MAX_BINS < SEL_SPAN) ? MAX_BINS : SEL_SPAN;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    logic [CNT_W-1:0] bin_count_reg;
    logic             hold_vld_reg;
    ctl_t             hold_ctl_reg;
    logic [3*W-1:0]   hold_data_reg;

    logic             accept;
    logic [CNT_W-1:0] lim;
    logic             idx_ok;
    ctl_t             ctl_next;
    logic signed [W-1:0] lo;
    logic signed [W-1:0] hi;

    assign busy        = hold_vld_reg && q_full;
    assign accept      = start && !busy;
    assign q_push      = hold_vld_reg && !q_full;
    assign q_push_ctl  = hold_ctl_reg;
    assign q_push_data = hold_data_reg;

    // entries past the table or past the selectable range are never valid
    assign lim    = (bin_count_reg > DEPTH_CNT) ? DEPTH_CNT : bin_count_reg;
    assign idx_ok = ({1'b0, bin_sel} < lim);
    assign lo     = (bound_a > bound_b) ? bound_b : bound_a;
    assign hi     = (bound_a > bound_b) ? bound_a : bound_b;

    always_comb
    begin
        ctl_next.lim = lim;
        ctl_next.sel = bin_sel;
        case (mode)
            MODE_WRITE:  ctl_next.op = idx_ok ? OP_WRITE : OP_REJECT;
            MODE_READ:   ctl_next.op = idx_ok ? OP_READ : OP_REJECT;
            MODE_LOOKUP:
            begin
                ctl_next.op  = OP_LOOKUP;
                ctl_next.sel = '0;
            end
            default:
            begin
                ctl_next.op  = OP_REJECT;
                ctl_next.sel = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg <= BIN_COUNT_RST;
            hold_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                bin_count_reg <= cfg_wr_data;
            if (accept)
                hold_vld_reg <= 1'b1;
            else if (q_push)
                hold_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_ctl_reg  <= ctl_next;
            hold_data_reg <= {angle, lo, hi};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pwbl_back.sv =====
// back section: bin table, read and write execution, pipelined lookup scan
// depends on pwbl_pkg and the assertion macro header; fed by pwbl_queue
`default_nettype none

`include "phi_wrapped_bin_lookup_core_defines.svh"

module pwbl_back
    import pwbl_pkg::*;
#(
    parameter int MAX_BINS   = 64,
    parameter int TURN_BITS  = 16,
    parameter int ANGLE_BITS = 20
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    q_empty,
    input  wire ctl_t                    q_head_ctl,
    input  wire logic [3*ANGLE_BITS-1:0] q_head_data,
    output logic                         q_pop,
    output logic                         done,
    output logic [SEL_W-1:0]             found_bin,
    output logic                         inside_hit,
    output logic [1:0]                   status,
    output logic signed [ANGLE_BITS-1:0] low_out,
    output logic signed [ANGLE_BITS-1:0] high_out,
    output logic signed [ANGLE_BITS-1:0] center_out
);

    localparam int W     = ANGLE_BITS;
    localparam int DEPTH = (MAX_BINS < SEL_SPAN) ? MAX_BINS : SEL_SPAN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = (W + 2 > TURN_BITS + 1) ? W + 2 : TURN_BITS + 1;
    localparam int XW    = FW + 2;
    localparam logic [FW-1:0] HALF  = FW'(1) << (TURN_BITS - 1);
    localparam logic [FW-1:0] KMASK = {FW{1'b1}} << TURN_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DRAIN
    } state_t;

    // bin table
    logic signed [W-1:0] low_mem  [DEPTH];
    logic signed [W-1:0] high_mem [DEPTH];
    logic [DEPTH-1:0]    valid_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    // control
    state_t              state_reg;
    logic                done_reg;
    logic [SEL_W-1:0]    found_reg;
    logic                inside_reg;
    status_t             status_reg;
    logic signed [W-1:0] low_reg;
    logic signed [W-1:0] high_reg;
    logic signed [W-1:0] center_reg;
    logic [CNT_W-1:0]    scan_cnt_reg;
    logic [CNT_W-1:0]    cur_lim_reg;
    logic [SEL_W-1:0]    cur_sel_reg;
    logic signed [W-1:0] cur_angle_reg;

    // best candidate so far
    logic                have_reg;
    logic                hit_reg;
    logic [SEL_W-1:0]    best_idx_reg;
    logic [XW-1:0]       best_dist_reg;
    logic signed [W-1:0] best_lo_reg;
    logic signed [W-1:0] best_hi_reg;
    logic signed [W-1:0] best_c_reg;

    // scan pipeline
    logic                s1_live_reg;
    logic [SEL_W-1:0]    s1_idx_reg;
    logic signed [W-1:0] rd_lo_reg;
    logic signed [W-1:0] rd_hi_reg;
    logic                rd_vld_reg;

    logic                s2_live_reg;
    logic [SEL_W-1:0]    s2_idx_reg;
    logic signed [W-1:0] s2_lo_reg;
    logic signed [W-1:0] s2_hi_reg;
    logic signed [W-1:0] s2_c_reg;
    logic [W:0]          s2_ad_reg;
    logic                s2_neg_reg;

    logic                 s3_live_reg;
    logic [SEL_W-1:0]     s3_idx_reg;
    logic signed [W-1:0]  s3_lo_reg;
    logic signed [W-1:0]  s3_hi_reg;
    logic signed [W-1:0]  s3_c_reg;
    logic signed [XW-1:0] s3_f_reg;

    logic                s4_live_reg;
    logic [SEL_W-1:0]    s4_idx_reg;
    logic signed [W-1:0] s4_lo_reg;
    logic signed [W-1:0] s4_hi_reg;
    logic signed [W-1:0] s4_c_reg;
    logic                s4_inside_reg;
    logic [XW-1:0]       s4_dist_reg;

    // combinational pieces
    logic signed [W-1:0]  head_angle;
    logic signed [W-1:0]  head_lo;
    logic signed [W-1:0]  head_hi;
    logic signed [W:0]    w_sum;
    logic signed [W-1:0]  w_center;
    logic signed [W:0]    r_sum;
    logic signed [W-1:0]  r_center;
    logic signed [W:0]    d_pos;
    logic signed [W:0]    d_neg;
    logic [FW-1:0]        rnd;
    logic [FW-1:0]        shift_amt;
    logic signed [XW-1:0] angle_x;
    logic signed [XW-1:0] shift_x;
    logic signed [XW-1:0] fold;
    logic signed [XW-1:0] lo_x;
    logic signed [XW-1:0] hi_x;
    logic signed [XW-1:0] c_x;
    logic signed [XW-1:0] c_minus_f;
    logic signed [XW-1:0] f_minus_c;
    logic                 pipe_empty;

    assign head_angle = $signed(q_head_data[3*W-1:2*W]);
    assign head_lo    = $signed(q_head_data[2*W-1:W]);
    assign head_hi    = $signed(q_head_data[W-1:0]);

    assign q_pop   = (state_reg == S_IDLE) && !q_empty;
    assign wr_en   = q_pop && (q_head_ctl.op == OP_WRITE);
    assign wr_addr = q_head_ctl.sel[AW-1:0];
    assign rd_addr = (state_reg == S_SCAN) ? scan_cnt_reg[AW-1:0] : q_head_ctl.sel[AW-1:0];

    // floor of the mean is the sum shifted right with its sign kept
    assign w_sum    = {head_lo[W-1], head_lo} + {head_hi[W-1], head_hi};
    assign w_center = w_sum[W:1];
    assign r_sum    = {rd_lo_reg[W-1], rd_lo_reg} + {rd_hi_reg[W-1], rd_hi_reg};
    assign r_center = r_sum[W:1];

    // stage 2: distance from center, both signs in parallel
    assign d_pos = {cur_angle_reg[W-1], cur_angle_reg} - {r_center[W-1], r_center};
    assign d_neg = {r_center[W-1], r_center} - {cur_angle_reg[W-1], cur_angle_reg};

    // stage 3: round turn count half away from zero, fold by whole turns
    assign rnd       = {{(FW-W-1){1'b0}}, s2_ad_reg} + HALF;
    assign shift_amt = rnd & KMASK;
    assign angle_x   = {{(XW-W){cur_angle_reg[W-1]}}, cur_angle_reg};
    assign shift_x   = $signed({2'b00, shift_amt});
    assign fold      = s2_neg_reg ? (angle_x + shift_x) : (angle_x - shift_x);

    // stage 4: containment and center distance
    assign lo_x      = {{(XW-W){s3_lo_reg[W-1]}}, s3_lo_reg};
    assign hi_x      = {{(XW-W){s3_hi_reg[W-1]}}, s3_hi_reg};
    assign c_x       = {{(XW-W){s3_c_reg[W-1]}}, s3_c_reg};
    assign c_minus_f = c_x - s3_f_reg;
    assign f_minus_c = s3_f_reg - c_x;

    assign pipe_empty = !s1_live_reg && !s2_live_reg && !s3_live_reg && !s4_live_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            low_mem[wr_addr]  <= head_lo;
            high_mem[wr_addr] <= head_hi;
        end
        rd_lo_reg  <= low_mem[rd_addr];
        rd_hi_reg  <= high_mem[rd_addr];
        rd_vld_reg <= valid_reg[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= scan_cnt_reg[SEL_W-1:0];

        s2_idx_reg <= s1_idx_reg;
        s2_lo_reg  <= rd_lo_reg;
        s2_hi_reg  <= rd_hi_reg;
        s2_c_reg   <= r_center;
        s2_neg_reg <= d_pos[W];
        s2_ad_reg  <= d_pos[W] ? d_neg : d_pos;

        s3_idx_reg <= s2_idx_reg;
        s3_lo_reg  <= s2_lo_reg;
        s3_hi_reg  <= s2_hi_reg;
        s3_c_reg   <= s2_c_reg;
        s3_f_reg   <= fold;

        s4_idx_reg    <= s3_idx_reg;
        s4_lo_reg     <= s3_lo_reg;
        s4_hi_reg     <= s3_hi_reg;
        s4_c_reg      <= s3_c_reg;
        s4_inside_reg <= (s3_f_reg >= lo_x) && (s3_f_reg < hi_x);
        s4_dist_reg   <= (c_x > s3_f_reg) ? c_minus_f : f_minus_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            s1_live_reg <= 1'b0;
            s2_live_reg <= 1'b0;
            s3_live_reg <= 1'b0;
            s4_live_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            s1_live_reg <= (state_reg == S_SCAN);
            // unwritten bins drop out here
            s2_live_reg <= s1_live_reg && rd_vld_reg;
            s3_live_reg <= s2_live_reg;
            s4_live_reg <= s3_live_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            found_reg     <= '0;
            inside_reg    <= 1'b0;
            status_reg    <= STAT_OK;
            low_reg       <= '0;
            high_reg      <= '0;
            center_reg    <= '0;
            scan_cnt_reg  <= '0;
            cur_lim_reg   <= '0;
            cur_sel_reg   <= '0;
            cur_angle_reg <= '0;
            have_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            best_idx_reg  <= '0;
            best_dist_reg <= '0;
            best_lo_reg   <= '0;
            best_hi_reg   <= '0;
            best_c_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            // first containing bin wins; before that keep the nearest center
            if (s4_live_reg && !hit_reg)
            begin
                if (s4_inside_reg)
                begin
                    hit_reg      <= 1'b1;
                    have_reg     <= 1'b1;
                    best_idx_reg <= s4_idx_reg;
                    best_lo_reg  <= s4_lo_reg;
                    best_hi_reg  <= s4_hi_reg;
                    best_c_reg   <= s4_c_reg;
                end
                else if (!have_reg || (s4_dist_reg < best_dist_reg))
                begin
                    have_reg      <= 1'b1;
                    best_idx_reg  <= s4_idx_reg;
                    best_dist_reg <= s4_dist_reg;
                    best_lo_reg   <= s4_lo_reg;
                    best_hi_reg   <= s4_hi_reg;
                    best_c_reg    <= s4_c_reg;
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cur_sel_reg   <= q_head_ctl.sel;
                        cur_lim_reg   <= q_head_ctl.lim;
                        cur_angle_reg <= head_angle;
                        case (q_head_ctl.op)
                            OP_WRITE:
                            begin
                                done_reg   <= 1'b1;
                                found_reg  <= q_head_ctl.sel;
                                inside_reg <= 1'b0;
                                status_reg <= STAT_OK;
                                low_reg    <= head_lo;
                                high_reg   <= head_hi;
                                center_reg <= w_center;
                            end
                            OP_READ:
                            begin
                                state_reg <= S_READ;
                            end
                            OP_LOOKUP:
                            begin
                                if (q_head_ctl.lim == '0)
                                begin
                                    done_reg   <= 1'b1;
                                    found_reg  <= '0;
                                    inside_reg <= 1'b0;
                                    status_reg <= STAT_NO_BIN;
                                    low_reg    <= '0;
                                    high_reg   <= '0;
                                    center_reg <= '0;
                                end
                                else
                                begin
                                    scan_cnt_reg <= '0;
                                    have_reg     <= 1'b0;
                                    hit_reg      <= 1'b0;
                                    state_reg    <= S_SCAN;
                                end
                            end
                            default:
                            begin
                                done_reg   <= 1'b1;
                                found_reg  <= q_head_ctl.sel;
                                inside_reg <= 1'b0;
                                status_reg <= STAT_BAD_INDEX;
                                low_reg    <= '0;
                                high_reg   <= '0;
                                center_reg <= '0;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    done_reg   <= 1'b1;
                    found_reg  <= cur_sel_reg;
                    inside_reg <= 1'b0;
                    if (rd_vld_reg)
                    begin
                        status_reg <= STAT_OK;
                        low_reg    <= rd_lo_reg;
                        high_reg   <= rd_hi_reg;
                        center_reg <= r_center;
                    end
                    else
                    begin
                        status_reg <= STAT_NO_BIN;
                        low_reg    <= '0;
                        high_reg   <= '0;
                        center_reg <= '0;
                    end
                    state_reg <= S_IDLE;
                end
                S_SCAN:
                begin
                    if ((scan_cnt_reg + CNT_W'(1)) == cur_lim_reg)
                        state_reg <= S_DRAIN;
                    else
                        scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                end
                S_DRAIN:
                begin
                    if (pipe_empty)
                    begin
                        done_reg   <= 1'b1;
                        found_reg  <= have_reg ? best_idx_reg : '0;
                        inside_reg <= hit_reg;
                        status_reg <= have_reg ? STAT_OK : STAT_NO_BIN;
                        low_reg    <= have_reg ? best_lo_reg : '0;
                        high_reg   <= have_reg ? best_hi_reg : '0;
                        center_reg <= have_reg ? best_c_reg : '0;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done       = done_reg;
    assign found_bin  = found_reg;
    assign inside_hit = inside_reg;
    assign status     = status_reg;
    assign low_out    = low_reg;
    assign high_out   = high_reg;
    assign center_out = center_reg;

    `PWBL_ASSERT_NOW(a_scan_in_range, clk, rst_n, state_reg == S_SCAN, scan_cnt_reg < cur_lim_reg, "scan index past bin limit")
    `PWBL_ASSERT_NEXT(a_pop_progress, clk, rst_n, q_pop, done_reg || (state_reg != S_IDLE), "command popped without result or work")
    `PWBL_ASSERT_NOW(a_hit_has_best, clk, rst_n, hit_reg, have_reg, "hit recorded without a chosen bin")

endmodule

`default_nettype wire

// ===== rtl/phi_wrapped_bin_lookup_core.sv =====
// top level of the angular bin lookup core
// depends on pwbl_pkg, pwbl_front, pwbl_queue and pwbl_back
`default_nettype none

// A command is taken when start is high and busy is low; busy rises only when
// the capture register holds a command and the two-entry queue behind it is
// full. Each command gives one result, shown on the result ports for a single
// cycle while done is high; there is no way to hold it off. Once the back
// section is free, a write or a rejected command passes the capture register
// and the queue and gives its result as it leaves the queue; a read also
// passes the read state. A lookup walks the active bins, the smaller of
// bin_count and the table depth, through the single read port of the bin
// table, one bin per cycle, followed by a four-stage fold and compare
// pipeline that drains before done rises. Commands run one at a time in the
// back section; the front takes them until queue and capture register fill.
// Valid bits of the table clear at reset, so the block is ready at once.
module phi_wrapped_bin_lookup_core
    import pwbl_pkg::*;
#(
    parameter int MAX_BINS   = 64,
    parameter int TURN_BITS  = 16,
    parameter int ANGLE_BITS = 20
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         cfg_wr_en,
    input  wire logic [CNT_W-1:0]             cfg_wr_data,
    input  wire logic [1:0]                   mode,
    input  wire logic [SEL_W-1:0]             bin_sel,
    input  wire logic signed [ANGLE_BITS-1:0] angle,
    input  wire logic signed [ANGLE_BITS-1:0] bound_a,
    input  wire logic signed [ANGLE_BITS-1:0] bound_b,
    output logic                              done,
    output logic [SEL_W-1:0]                  found_bin,
    output logic                              inside_hit,
    output logic [1:0]                        status,
    output logic signed [ANGLE_BITS-1:0]      low_out,
    output logic signed [ANGLE_BITS-1:0]      high_out,
    output logic signed [ANGLE_BITS-1:0]      center_out
);

    localparam int DATA_W = 3 * ANGLE_BITS;

    logic              q_push;
    ctl_t              q_push_ctl;
    logic [DATA_W-1:0] q_push_data;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    ctl_t              q_head_ctl;
    logic [DATA_W-1:0] q_head_data;

    pwbl_front #(
        .MAX_BINS   (MAX_BINS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mode        (mode),
        .bin_sel     (bin_sel),
        .angle       (angle),
        .bound_a     (bound_a),
        .bound_b     (bound_b),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_ctl  (q_push_ctl),
        .q_push_data (q_push_data)
    );

    pwbl_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_ctl  (q_push_ctl),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_ctl  (q_head_ctl),
        .head_data (q_head_data)
    );

    pwbl_back #(
        .MAX_BINS   (MAX_BINS),
        .TURN_BITS  (TURN_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head_ctl  (q_head_ctl),
        .q_head_data (q_head_data),
        .q_pop       (q_pop),
        .done        (done),
        .found_bin   (found_bin),
        .inside_hit  (inside_hit),
        .status      (status),
        .low_out     (low_out),
        .high_out    (high_out),
        .center_out  (center_out)
    );

endmodule

`default_nettype wire
